FILE: sv/pltsv_pkg.sv
// Shared types, constants and helpers for the polyline to strip vertex block.
// Used by the front end, the job queue, the back end and the top level.
// Has no dependencies of its own.
package pltsv_pkg;

	// Coordinate and register widths.
	localparam int COORD_W = 16;
	localparam int HW_W    = 15;
	localparam int COLOR_W = 8;

	// Packed point as it travels in tdata, plus the tdata width rounded to bytes.
	localparam int PT_W    = 2 * COORD_W + 3 * COLOR_W;
	localparam int TDATA_W = ((PT_W + 7) / 8) * 8;

	// Reset value of the half width register.
	localparam logic [HW_W-1:0] HW_RESET = HW_W'(82);

	// Job queue depth.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Width of the saturating sum.
	localparam int SUM_W = ((COORD_W > HW_W + 1) ? COORD_W : HW_W + 1) + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [HW_W-1:0] hw_t;

	// Offset direction of one coordinate, in units of the half width.
	typedef logic [1:0] ofs_t;
	localparam ofs_t OFS_ZERO = 2'd0;
	localparam ofs_t OFS_POS  = 2'd1;
	localparam ofs_t OFS_NEG  = 2'd2;

	// Point layout: x in the lowest bits, then y, red, green, blue.
	typedef struct packed {
		color_t blue;
		color_t green;
		color_t red;
		coord_t y;
		coord_t x;
	} point_t;

	// One job: a point and the offset of its first vertex. The second vertex
	// uses the opposite offset. Last marks the second vertex as the final one.
	typedef struct packed {
		point_t pt;
		ofs_t   sx;
		ofs_t   sy;
		logic   last;
	} job_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// Opposite offset direction.
	function automatic ofs_t neg_ofs(input ofs_t s);
		ofs_t r;
		unique case (s)
			OFS_POS: r = OFS_NEG;
			OFS_NEG: r = OFS_POS;
			default: r = OFS_ZERO;
		endcase
		return r;
	endfunction

	// Coordinate displaced by plus, minus or zero half width, saturated.
	function automatic coord_t sat_offset(input coord_t c, input ofs_t s, input hw_t hw);
		localparam logic signed [SUM_W-1:0] SAT_HI =
			{{(SUM_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
		localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
		logic signed [SUM_W-1:0] a;
		logic signed [SUM_W-1:0] hh;
		logic signed [SUM_W-1:0] sum;
		a  = SUM_W'(c);
		hh = SUM_W'(hw);
		unique case (s)
			OFS_POS: sum = a + hh;
			OFS_NEG: sum = a - hh;
			default: sum = a;
		endcase
		if (sum > SAT_HI) begin
			sum = SAT_HI;
		end else if (sum < SAT_LO) begin
			sum = SAT_LO;
		end
		return coord_t'(sum[COORD_W-1:0]);
	endfunction

endpackage

FILE: sv/polyline_to_strip_vertices.sv
// Polyline to strip vertices, top level: half width register, front end,
// job queue and back end. Depends on pltsv_pkg, pltsv_front, pltsv_queue, pltsv_back.
//
// Points enter on the s_ stream (tdata: x, y, red, green, blue from the lowest
// bit up; tlast marks the final point). Vertices leave on the m_ stream with
// the same tdata layout; tlast marks the final vertex of the polyline.
// The first point of a polyline gives no vertices; each later point releases
// the pair of its predecessor; the last point releases its predecessor's pair
// and its own; a lone point gives one pair.
// The first vertex of a pair passes through the job queue and the output register
// before it is valid on m_, then vertices follow one per cycle while m_tready holds.
// Each point gives two vertices through the single output channel, which emits one
// vertex per cycle while the receiver is ready. A last point that closes a polyline
// of two or more points holds the input while the front end queues the end pair.
// A stalled receiver fills the output register and then the four job queue;
// the input then stalls until room frees up.
// Reset (arst_n low) empties the queue and the held points and loads the half
// width register with 82. cfg_we writes cfg_wdata into half width; write it
// only while no polyline is in flight.
module polyline_to_strip_vertices (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pltsv_pkg::HW_W-1:0]    cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// point_x, point_y, point_red, point_green, point_blue
	input  logic [pltsv_pkg::TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// vertex_x, vertex_y, vertex_red, vertex_green, vertex_blue
	output logic [pltsv_pkg::TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import pltsv_pkg::*;

	hw_t    half_width_q;
	logic   push;
	logic   pop;
	job_t   wjob;
	job_t   head;
	qstat_t qstat;

	// Half width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HW_RESET;
		end else if (cfg_we) begin
			half_width_q <= cfg_wdata;
		end
	end

	pltsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.push     (push),
		.job      (wjob),
		.qstat    (qstat)
	);

	pltsv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wjob),
		.pop    (pop),
		.rdata  (head),
		.stat   (qstat)
	);

	pltsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.half_width (half_width_q),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: sv/pltsv_queue.sv
// Small job queue between the front end and the back end.
// Depends on pltsv_pkg for the job and status types.
module pltsv_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pltsv_pkg::job_t  wdata,
	input  logic             pop,
	output pltsv_pkg::job_t  rdata,
	output pltsv_pkg::qstat_t stat
);
	import pltsv_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Status and head of the queue.
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = entry_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// The producer never writes a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full) else $error("queue written while full");

	// The consumer never reads an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("queue read while empty");

	// The fill count tracks the pointers.
	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != QCNT_W'(QDEPTH)) |->
		(QPTR_W'(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0]))
		else $error("fill count disagrees with pointers");

endmodule

FILE: sv/pltsv_front.sv
// Front end: accepts points, keeps the two held points and classifies each
// point into widening jobs. Depends on pltsv_pkg.
module pltsv_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pltsv_pkg::TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	output logic                          push,
	output pltsv_pkg::job_t               job,
	input  pltsv_pkg::qstat_t             qstat
);
	import pltsv_pkg::*;

	localparam logic [1:0] HELD_NONE = 2'd0;
	localparam logic [1:0] HELD_ONE  = 2'd1;
	localparam logic [1:0] HELD_TWO  = 2'd2;

	point_t     older_q;
	point_t     newer_q;
	logic [1:0] held_q;
	logic       pend_q;
	job_t       pend_job_q;

	point_t     cur;
	logic       acc;
	job_t       main_job;
	job_t       end_job;
	logic       main_push;

	assign cur      = point_t'(s_tdata[PT_W-1:0]);
	assign s_tready = !pend_q && !qstat.full;
	assign acc      = s_tvalid && s_tready;

	// Classify the accepted point against the held points.
	always_comb begin
		main_job.pt   = newer_q;
		main_job.sx   = OFS_NEG;
		main_job.sy   = OFS_ZERO;
		main_job.last = 1'b0;
		main_push     = 1'b1;
		unique case (held_q)
			HELD_NONE: begin
				// A lone point gives a horizontal pair; otherwise just store it.
				main_job.pt   = cur;
				main_job.last = 1'b1;
				main_push     = s_tlast;
			end
			HELD_ONE: begin
				// First point of the polyline.
				if (newer_q.x != cur.x) begin
					main_job.sx = OFS_ZERO;
					main_job.sy = OFS_POS;
				end
			end
			default: begin
				// Interior point: direction from predecessor to successor.
				if (cur.y == older_q.y) begin
					main_job.sx = OFS_ZERO;
					main_job.sy = OFS_POS;
				end else if (cur.x == older_q.x) begin
					main_job.sx = OFS_NEG;
					main_job.sy = OFS_ZERO;
				end else if ((cur.y > older_q.y) == (cur.x > older_q.x)) begin
					main_job.sx = OFS_NEG;
					main_job.sy = OFS_POS;
				end else begin
					main_job.sx = OFS_POS;
					main_job.sy = OFS_POS;
				end
			end
		endcase
	end

	// End point pair, held as the pending job and queued after its predecessor's pair once the queue has room.
	always_comb begin
		end_job.pt   = cur;
		end_job.last = 1'b1;
		if (newer_q.x != cur.x) begin
			end_job.sx = OFS_ZERO;
			end_job.sy = OFS_NEG;
		end else begin
			end_job.sx = OFS_POS;
			end_job.sy = OFS_ZERO;
		end
	end

	// A pending end pair waits for room in the queue.
	assign push = (pend_q && !qstat.full) || (acc && main_push);
	assign job  = pend_q ? pend_job_q : main_job;

	// Held points and pending end pair payload.
	always_ff @(posedge clk) begin
		if (acc && !s_tlast) begin
			older_q <= newer_q;
			newer_q <= cur;
		end
		if (acc && s_tlast) begin
			pend_job_q <= end_job;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_NONE;
			pend_q <= 1'b0;
		end else begin
			if (acc) begin
				if (s_tlast) begin
					held_q <= HELD_NONE;
					pend_q <= (held_q != HELD_NONE);
				end else if (held_q == HELD_NONE) begin
					held_q <= HELD_ONE;
				end else begin
					held_q <= HELD_TWO;
				end
			end else if (pend_q && !qstat.full) begin
				pend_q <= 1'b0;
			end
		end
	end

	// A pending end pair only exists right after a polyline closed.
	a_pend_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (held_q == HELD_NONE)) else $error("end pair pending with points held");

endmodule

FILE: sv/pltsv_back.sv
// Back end: expands each queued job into two displaced, saturated vertices
// and holds them in the output register. Depends on pltsv_pkg.
module pltsv_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pltsv_pkg::hw_t                half_width,
	input  pltsv_pkg::job_t               head,
	input  pltsv_pkg::qstat_t             qstat,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pltsv_pkg::TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import pltsv_pkg::*;

	logic   phase_q;
	logic   valid_q;
	point_t vtx_q;
	logic   last_q;

	logic   load;
	ofs_t   sx;
	ofs_t   sy;
	point_t vtx;

	assign load = !qstat.empty && (!valid_q || m_tready);
	assign pop  = load && phase_q;

	// Second vertex of a job takes the opposite offset.
	assign sx = phase_q ? neg_ofs(head.sx) : head.sx;
	assign sy = phase_q ? neg_ofs(head.sy) : head.sy;

	always_comb begin
		vtx   = head.pt;
		vtx.x = sat_offset(head.pt.x, sx, half_width);
		vtx.y = sat_offset(head.pt.y, sy, half_width);
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			vtx_q  <= vtx;
			last_q <= head.last && phase_q;
		end
	end

	// Output valid and vertex phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !phase_q;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = TDATA_W'(vtx_q);
	assign m_tlast  = last_q;

	// A job leaves the queue in the same cycle as its second vertex is loaded.
	a_pop_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !phase_q) else $error("job popped out of phase");

endmodule
